[rtl/core/hcbp_pkg.sv]
`timescale 1ns / 1ps
package hcbp_pkg;

	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;

	localparam int OP_W     = 2;
	localparam int SYM_W    = 8;
	localparam int CODE_W   = 32;
	localparam int LEN_W    = 6;
	localparam int BYTE_W   = 8;
	localparam int PEND_W   = 7;
	localparam int PCNT_W   = 3;

	localparam int SYM_IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int ACC_W     = MAX_CODE_LEN + PEND_W;
	localparam int TOT_W     = $clog2(ACC_W + 1);
	localparam int MAX_BYTES = (PEND_W + MAX_CODE_LEN) / BYTE_W;
	localparam int BUF_W     = MAX_BYTES * BYTE_W;
	localparam int BCNT_W    = $clog2(MAX_BYTES + 1);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD   = 2'd0,
		OP_ENCODE = 2'd1,
		OP_FLUSH  = 2'd2
	} op_t;

	function automatic logic [CODE_W-1:0] code_mask(input logic [LEN_W-1:0] len);
		logic [CODE_W:0] one;
		logic [CODE_W:0] m;
		one = (CODE_W + 1)'(1);
		m   = (one << len) - one;
		if (int'(len) >= CODE_W) begin
			code_mask = '1;
		end else begin
			code_mask = m[CODE_W-1:0];
		end
	endfunction

	function automatic logic [PEND_W-1:0] pend_mask(input logic [PCNT_W-1:0] cnt);
		logic [PEND_W:0] one;
		logic [PEND_W:0] m;
		one       = (PEND_W + 1)'(1);
		m         = (one << cnt) - one;
		pend_mask = m[PEND_W-1:0];
	endfunction

endpackage

[rtl/core/huffman_code_bit_packer_top.sv]
// Path: the first byte of an item is offered from the output register, which follows
// the table read stage; a busy output register holds the item in the read stage.
// Throughput: one item per cycle while each item emits at most one byte and out_ready
// is high; an item emitting N bytes (N up to 4) holds the output register and stalls
// the next item until its last byte transfers.
// Reset: arst_n clears the pending bit accumulator, pipeline valid flags and the
// per-symbol length valid bits at once; code words read as absent until loaded.
`timescale 1ns / 1ps
module huffman_code_bit_packer_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [hcbp_pkg::OP_W-1:0]   op,
	input  logic [hcbp_pkg::SYM_W-1:0]  symbol,
	input  logic [hcbp_pkg::CODE_W-1:0] code_word,
	input  logic [hcbp_pkg::LEN_W-1:0]  code_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [hcbp_pkg::BYTE_W-1:0] out_byte,
	output logic                        last
);
	import hcbp_pkg::*;

	logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
	logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] len_vld_q;

	logic                 in_xfer;
	logic                 sym_ok;
	logic [SYM_IDX_W-1:0] sym_idx;
	logic [LEN_W-1:0]     len_sat;
	logic                 load_wr;

	logic              vld_s1;
	logic [OP_W-1:0]   op_s1;
	logic              hit_s1;
	logic [CODE_W-1:0] code_s1;
	logic [LEN_W-1:0]  len_s1;

	logic [PEND_W-1:0] pend_bits_q;
	logic [PCNT_W-1:0] pend_cnt_q;

	logic [BUF_W-1:0]  obuf_q;
	logic [BCNT_W-1:0] ocnt_q;

	logic              buf_free;
	logic              s1_go;
	logic [LEN_W-1:0]  eff_len;
	logic [ACC_W-1:0]  acc;
	logic [TOT_W-1:0]  total;
	logic [BCNT_W-1:0] enc_n;
	logic [ACC_W-1:0]  shifted;
	logic [TOT_W-1:0]  lsh;
	logic [BUF_W-1:0]  enc_buf;
	logic [BYTE_W-1:0] fl_byte;

	logic [BCNT_W-1:0] emit_n;
	logic [BUF_W-1:0]  emit_buf;
	logic [PEND_W-1:0] pend_bits_d;
	logic [PCNT_W-1:0] pend_cnt_d;

	assign in_xfer = in_valid && in_ready;
	assign sym_ok  = ({1'b0, symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
	assign sym_idx = symbol[SYM_IDX_W-1:0];
	assign len_sat = (code_length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : code_length;
	assign load_wr = in_xfer && (op == OP_LOAD) && sym_ok;

	always_ff @(posedge clk) begin
		if (load_wr) begin
			code_mem[sym_idx] <= code_word & code_mask(len_sat);
			len_mem[sym_idx]  <= len_sat;
		end
		if (in_xfer) begin
			code_s1 <= code_mem[sym_idx];
			len_s1  <= len_mem[sym_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
		end else if (load_wr) begin
			len_vld_q[sym_idx] <= 1'b1;
		end
	end

	assign buf_free = (ocnt_q == '0) || ((ocnt_q == BCNT_W'(1)) && out_ready);
	assign s1_go    = vld_s1 && buf_free;
	assign in_ready = !vld_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_s1  <= op;
			hit_s1 <= sym_ok && len_vld_q[sym_idx];
		end
	end

	always_comb begin
		eff_len = hit_s1 ? len_s1 : '0;
		acc     = (ACC_W'(pend_bits_q) << eff_len)
		          | ((eff_len == '0) ? '0 : ACC_W'(code_s1));
		total   = TOT_W'(pend_cnt_q) + TOT_W'(eff_len);
		enc_n   = BCNT_W'(total >> 3);
		shifted = acc >> total[2:0];
		lsh     = TOT_W'(BUF_W) - TOT_W'({enc_n, 3'b000});
		enc_buf = shifted[BUF_W-1:0] << lsh;
		fl_byte = BYTE_W'({1'b0, pend_bits_q} << (PCNT_W + 1)'(4'd8 - {1'b0, pend_cnt_q}));

		emit_n      = '0;
		emit_buf    = enc_buf;
		pend_bits_d = pend_bits_q;
		pend_cnt_d  = pend_cnt_q;
		case (op_s1)
			OP_ENCODE: begin
				emit_n      = enc_n;
				pend_bits_d = acc[PEND_W-1:0] & pend_mask(total[2:0]);
				pend_cnt_d  = total[2:0];
			end
			OP_FLUSH: begin
				if (pend_cnt_q != '0) begin
					emit_n      = BCNT_W'(1);
					emit_buf    = {fl_byte, {(BUF_W - BYTE_W){1'b0}}};
					pend_bits_d = '0;
					pend_cnt_d  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (s1_go) begin
			pend_bits_q <= pend_bits_d;
			pend_cnt_q  <= pend_cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocnt_q <= '0;
		end else if (s1_go && (emit_n != '0)) begin
			ocnt_q <= emit_n;
		end else if (out_valid && out_ready) begin
			ocnt_q <= ocnt_q - BCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && (emit_n != '0)) begin
			obuf_q <= emit_buf;
		end else if (out_valid && out_ready) begin
			obuf_q <= obuf_q << BYTE_W;
		end
	end

	assign out_valid = (ocnt_q != '0);
	assign out_byte  = obuf_q[BUF_W-1 -: BYTE_W];
	assign last      = (ocnt_q == BCNT_W'(1));

	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_bits_q & ~pend_mask(pend_cnt_q)) == '0)
		else $error("pending bits set above pending count");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (vld_s1 && out_valid))
		else $error("input stalled without a held result");

	a_flush_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && (op_s1 == OP_FLUSH) && (pend_cnt_q != '0))
		|=> (out_valid && last && (pend_cnt_q == '0)))
		else $error("flush did not emit a single final byte");

	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> out_valid)
		else $error("byte burst ended before last");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= BCNT_W'(MAX_BYTES))
		else $error("output byte count out of range");

endmodule

[tb/tb_huffman_code_bit_packer_top.sv]
`timescale 1ns / 1ps
module tb_huffman_code_bit_packer_top;
	import hcbp_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 80;

	typedef struct {
		logic [BYTE_W-1:0] byte_val;
		logic              last_flag;
	} packed_byte_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [OP_W-1:0]     op;
	logic [SYM_W-1:0]    symbol;
	logic [CODE_W-1:0]   code_word;
	logic [LEN_W-1:0]    code_length;
	logic                out_valid;
	logic                out_ready;
	logic [BYTE_W-1:0]   out_byte;
	logic                last;

	logic [CODE_W-1:0]   code_mem [SYMBOL_COUNT];
	logic [LEN_W-1:0]    len_mem [SYMBOL_COUNT];
	logic [PEND_W-1:0]   acc_bits;
	logic [PCNT_W-1:0]   acc_count;
	bit                  loaded [SYMBOL_COUNT];
	logic [SYM_W-1:0]    loaded_syms [$];
	packed_byte_t        byte_q [$];
	packed_byte_t        got;

	int  err_cnt;
	bit  tx_idle_en;
	bit  rx_idle_en;
	int  hold_reqs;
	int  hold_seen;
	int  hold_left;

	huffman_code_bit_packer_top DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.symbol      (symbol),
		.code_word   (code_word),
		.code_length (code_length),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("status: fail");
		$finish;
	end

	// expected bytes for one accepted transfer
	task automatic pack_code(input logic [OP_W-1:0] o, input logic [SYM_W-1:0] s,
		input logic [CODE_W-1:0] w, input logic [LEN_W-1:0] l);
		logic [63:0] acc;
		int          ln;
		int          total;
		int          n;
		packed_byte_t e;
		ln = l;
		if (o == OP_LOAD) begin
			if (ln > MAX_CODE_LEN)
				ln = MAX_CODE_LEN;
			len_mem[s]  = LEN_W'(ln);
			code_mem[s] = CODE_W'(64'(w) & ((64'd1 << ln) - 64'd1));
			if (!loaded[s]) begin
				loaded[s] = 1'b1;
				loaded_syms.push_back(s);
			end
		end else if (o == OP_ENCODE) begin
			ln = len_mem[s];
			if (ln != 0) begin
				acc   = (64'(acc_bits) << ln) | (64'(code_mem[s]) & ((64'd1 << ln) - 64'd1));
				total = int'(acc_count) + ln;
				n     = total / 8;
				for (int i = 0; i < n; i++) begin
					total       -= 8;
					e.byte_val  = BYTE_W'(acc >> total);
					e.last_flag = (i == n - 1);
					byte_q.push_back(e);
				end
				acc_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
				acc_count = PCNT_W'(total);
			end
		end else if (o == OP_FLUSH) begin
			if (acc_count != 0) begin
				e.byte_val  = BYTE_W'({acc_bits, 1'b0} << (7 - acc_count));
				e.last_flag = 1'b1;
				byte_q.push_back(e);
				acc_bits  = '0;
				acc_count = '0;
			end
		end
	endtask

	task automatic idle_tx(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_item(input logic [OP_W-1:0] o, input logic [SYM_W-1:0] s,
		input logic [CODE_W-1:0] w, input logic [LEN_W-1:0] l);
		if (tx_idle_en && $urandom_range(99) < 20)
			idle_tx($urandom_range(4, 1));
		in_valid    <= 1'b1;
		op          <= o;
		symbol      <= s;
		code_word   <= w;
		code_length <= l;
		do @(posedge clk); while (!in_ready);
		pack_code(o, s, w, l);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (byte_q.size() != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_random();
		int r;
		r = $urandom_range(99);
		if (r < 20 || loaded_syms.size() == 0) begin
			r = $urandom_range(99);
			send_item(OP_LOAD, SYM_W'($urandom), $urandom,
				(r < 10) ? LEN_W'(0) :
				(r < 20) ? LEN_W'($urandom_range(63, 33)) : LEN_W'($urandom_range(32, 1)));
		end else if (r < 85) begin
			send_item(OP_ENCODE, loaded_syms[$urandom_range(loaded_syms.size() - 1)],
				$urandom, LEN_W'($urandom));
		end else if (r < 95) begin
			send_item(OP_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
		end else begin
			send_item(OP_UNUSED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
		end
	endtask

	task automatic test_table_corners();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_item(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		send_item(OP_FLUSH, 8'h00, 32'h0, 6'h0);
		send_item(OP_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd32);
		send_item(OP_LOAD, 8'hFF, 32'h0, 6'd1);
		send_item(OP_LOAD, 8'h01, 32'hFFFF_FFFF, 6'd0);
		send_item(OP_LOAD, 8'h02, 32'hA5A5_5A5A, 6'd63);
		send_item(OP_LOAD, 8'h03, 32'hFFFF_FF55, 6'd7);
		send_item(OP_LOAD, 8'h04, 32'h1234_56C3, 6'd8);
		send_item(OP_LOAD, 8'h05, 32'h8000_0001, 6'd33);
		send_item(OP_ENCODE, 8'h00, 32'h0, 6'h0);
		send_item(OP_ENCODE, 8'h01, 32'h0, 6'h0);
		send_item(OP_ENCODE, 8'h03, 32'h0, 6'h0);
		send_item(OP_ENCODE, 8'h00, 32'h0, 6'h0);
		send_item(OP_ENCODE, 8'hFF, 32'h0, 6'h0);
		send_item(OP_ENCODE, 8'h02, 32'h0, 6'h0);
		send_item(OP_ENCODE, 8'h04, 32'h0, 6'h0);
		send_item(OP_FLUSH, 8'h00, 32'h0, 6'h0);
		send_item(OP_FLUSH, 8'h00, 32'h0, 6'h0);
		send_item(OP_ENCODE, 8'h05, 32'h0, 6'h0);
		send_item(OP_UNUSED, 8'h00, 32'h0, 6'h0);
		send_item(OP_ENCODE, 8'h03, 32'h0, 6'h0);
		send_item(OP_FLUSH, 8'h00, 32'h0, 6'h0);
		wait_drain();
	endtask

	task automatic test_random_stream();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (25) send_random();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (25) send_random();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (25) send_random();
		wait_drain();
	endtask

	task automatic test_output_stall();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		send_item(OP_LOAD, 8'h10, $urandom, 6'd31);
		send_item(OP_LOAD, 8'h11, $urandom, 6'd29);
		hold_reqs++;
		for (int i = 0; i < 14; i++)
			send_item(OP_ENCODE, (i % 2) ? 8'h10 : 8'h11, 32'h0, 6'h0);
		send_item(OP_FLUSH, 8'h00, 32'h0, 6'h0);
		rx_idle_en = 1'b1;
		wait_drain();
	endtask

	task automatic test_drain_pause();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (6) send_random();
		wait_drain();
		repeat (6) send_random();
		send_item(OP_FLUSH, 8'h00, 32'h0, 6'h0);
		wait_drain();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_reqs != hold_seen) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= !(rx_idle_en && $urandom_range(99) < 20);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (byte_q.size() == 0) begin
				$error("unexpected transfer: out_byte %02h last %0b", out_byte, last);
				err_cnt++;
			end else begin
				got = byte_q.pop_front();
				if (out_byte !== got.byte_val) begin
					$error("out_byte: expected %02h actual %02h", got.byte_val, out_byte);
					err_cnt++;
				end
				if (last !== got.last_flag) begin
					$error("last: expected %0b actual %0b", got.last_flag, last);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		err_cnt     = 0;
		hold_reqs   = 0;
		tx_idle_en  = 1'b0;
		rx_idle_en  = 1'b0;
		acc_bits    = '0;
		acc_count   = '0;
		for (int i = 0; i < SYMBOL_COUNT; i++) begin
			len_mem[i]  = '0;
			code_mem[i] = '0;
			loaded[i]   = 1'b0;
		end
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		op          <= OP_LOAD;
		symbol      <= '0;
		code_word   <= '0;
		code_length <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_table_corners();
		test_random_stream();
		test_output_stall();
		test_drain_pause();
		repeat (12) @(posedge clk);
		if (err_cnt == 0 && byte_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
